/* rtl/icm_pkg.sv */
// Package for the incline calibration map: fixed-point constants, codes and types.
// Shared by icm_div and incline_calibration_map; depends on nothing else.
package icm_pkg;

  localparam int MaxPoints = 10;
  localparam int FracBits  = 8;
  localparam int IdxW      = $clog2(MaxPoints);

  localparam int ValW    = 12;
  localparam int DesW    = 14;
  localparam int CountW  = 4;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 4;

  // Serial divider sizes: the magnitude of a 13 x 12 bit product over a 12-bit span.
  localparam int NumW = 24;
  localparam int DenW = 12;
  localparam int CntW = $clog2(NumW);

  localparam logic [ValW-1:0]   FullScale   = ValW'(15 << FracBits);
  localparam logic [CountW-1:0] MaxCount    = CountW'(MaxPoints);
  localparam logic [CountW-1:0] MinSegCount = CountW'(2);

  localparam logic [CfgIdxW-1:0] CfgMapValid   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPointCount = CfgIdxW'(1);

  localparam logic CmdWrite   = 1'b0;
  localparam logic CmdConvert = 1'b1;

  typedef enum logic [2:0] {
    StFlat        = 3'd0,
    StClampLow    = 3'd1,
    StClampHigh   = 3'd2,
    StIdentity    = 3'd3,
    StBelowRange  = 3'd4,
    StAboveRange  = 3'd5,
    StCalibrated  = 3'd6
  } status_e;

  typedef struct packed {
    logic [ValW-1:0] meas;
    logic [ValW-1:0] cmd;
  } point_t;

endpackage

/* rtl/icm_div.sv */
// Restoring serial divider of the incline calibration map, one quotient bit per cycle.
// Depends on icm_pkg for its widths.
module icm_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [icm_pkg::NumW-1:0] num_i,
  input  logic [icm_pkg::DenW-1:0] den_i,
  output logic                     done_o,
  output logic [icm_pkg::NumW-1:0] quo_o,
  output logic                     rem_nz_o
);
  import icm_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(NumW - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   rem_sh;
  logic            ge;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign rem_sh = {rem_q[DenW-1:0], num_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_d = {num_q[NumW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o   = done_q;
  assign quo_o    = num_q;
  assign rem_nz_o = |rem_q;

endmodule

/* rtl/incline_calibration_map.sv */
// Incline calibration map: desired incline to treadmill command through a point table.
// Depends on icm_pkg and icm_div.
//
// A write beat stores one calibration point in a 10-entry table memory and gives no
// result. A convert beat gives one result. Flat, negative and uncalibrated requests
// finish without reading the table. Otherwise the table memory, with its single,
// registered read port, is walked one entry per cycle: the first and last points are
// read to test the range, then points are read in order until the segment holding the
// desired value is found or the last point in use is reached. The segment is interpolated
// with a multiply state and, unless its span is zero, a serial divide. Only one beat is in
// the block at a time; a finished result waits in the output register while the next beat
// is taken.
module incline_calibration_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [icm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [icm_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [icm_pkg::CountW-1:0]  point_index_i,
  input  logic [icm_pkg::ValW-1:0]    point_measured_i,
  input  logic [icm_pkg::ValW-1:0]    point_command_i,
  input  logic signed [icm_pkg::DesW-1:0] desired_incline_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [icm_pkg::ValW-1:0]    command_incline_o,
  output icm_pkg::status_e            status_o
);
  import icm_pkg::*;

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SFirst = 7'b0000010,
    SLast  = 7'b0000100,
    SScan  = 7'b0001000,
    SMul   = 7'b0010000,
    SDiv   = 7'b0100000,
    SFin   = 7'b1000000
  } state_e;

  // Extra state for handing the result to the output register.
  logic done_q, done_d;

  state_e state_q, state_d;

  logic                  map_valid_q;
  logic [CountW-1:0]     point_count_q;
  logic [CountW-1:0]     cnt_eff;
  logic [IdxW-1:0]       last_idx;

  point_t                mem_q [MaxPoints];
  point_t                rd_data_q;
  logic [IdxW-1:0]       rd_addr;
  logic                  wr_en;

  logic [DesW-2:0]       d_q, d_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  point_t                prev_q, prev_d;
  logic [ValW-1:0]       last_cmd_q, last_cmd_d;
  logic [ValW-1:0]       sy0_q, sy0_d, sy1_q, sy1_d, sx0_q, sx0_d, dx_q, dx_d;
  logic signed [25:0]    prod_q, prod_d;
  logic signed [13:0]    q_q, q_d;
  logic [ValW-1:0]       res_q, res_d;
  status_e               st_q, st_d;

  logic                  out_valid_q;
  logic [ValW-1:0]       out_cmd_q;
  status_e               out_st_q;
  logic                  out_load;

  logic                  accept;
  logic [DesW-2:0]       d_in;
  logic [DesW-2:0]       cur_meas;
  logic [DesW-2:0]       prev_meas;
  logic [ValW-1:0]       last_clamped;
  logic [ValW-1:0]       cur_clamped;
  logic signed [12:0]    dy;
  logic [ValW:0]         dd;
  logic [NumW-1:0]       prod_mag;
  logic [12:0]           q_mag;
  logic                  div_start;
  logic                  div_done;
  logic [NumW-1:0]       div_quo;
  logic                  div_rem_nz;
  logic signed [14:0]    y;

  assign cnt_eff  = (point_count_q > MaxCount) ? MaxCount : point_count_q;
  assign last_idx = IdxW'(cnt_eff - CountW'(1));

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q   <= 1'b0;
      point_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMapValid:   map_valid_q   <= cfg_data_i[0];
        CfgPointCount: point_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == SIdle) && !done_q;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_en      = accept && (cmd_i == CmdWrite) && (point_index_i < MaxCount);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[point_index_i[IdxW-1:0]] <= '{meas: point_measured_i, cmd: point_command_i};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign d_in         = desired_incline_i[DesW-2:0];
  assign cur_meas     = {1'b0, rd_data_q.meas};
  assign prev_meas    = {1'b0, prev_q.meas};
  assign last_clamped = (last_cmd_q > FullScale) ? FullScale : last_cmd_q;
  assign cur_clamped  = (rd_data_q.cmd > FullScale) ? FullScale : rd_data_q.cmd;

  assign dy       = $signed({1'b0, sy1_q}) - $signed({1'b0, sy0_q});
  assign dd       = {1'b0, d_q[ValW-1:0]} - {1'b0, sx0_q};
  assign prod_mag = prod_d[25] ? NumW'(-prod_d) : NumW'(prod_d);
  assign q_mag    = div_quo[12:0];
  assign y        = $signed({3'b000, sy0_q}) + $signed({q_q[13], q_q});

  always_comb begin
    state_d    = state_q;
    done_d     = done_q;
    d_d        = d_q;
    idx_d      = idx_q;
    prev_d     = prev_q;
    last_cmd_d = last_cmd_q;
    sy0_d      = sy0_q;
    sy1_d      = sy1_q;
    sx0_d      = sx0_q;
    dx_d       = dx_q;
    prod_d     = prod_q;
    q_d        = q_q;
    res_d      = res_q;
    st_d       = st_q;
    rd_addr    = '0;
    div_start  = 1'b0;
    case (state_q)
      SIdle: begin
        if (accept && (cmd_i == CmdConvert)) begin
          d_d = d_in;
          if (desired_incline_i == '0) begin
            res_d  = '0;
            st_d   = StFlat;
            done_d = 1'b1;
          end else if (desired_incline_i[DesW-1]) begin
            res_d  = '0;
            st_d   = StClampLow;
            done_d = 1'b1;
          end else if (!map_valid_q || (cnt_eff < MinSegCount)) begin
            if (d_in > {1'b0, FullScale}) begin
              res_d = FullScale;
              st_d  = StClampHigh;
            end else begin
              res_d = d_in[ValW-1:0];
              st_d  = StIdentity;
            end
            done_d = 1'b1;
          end else begin
            rd_addr = '0;
            state_d = SFirst;
          end
        end
      end
      SFirst: begin
        prev_d = rd_data_q;
        if (d_q < cur_meas) begin
          res_d   = (d_q > {1'b0, FullScale}) ? FullScale : d_q[ValW-1:0];
          st_d    = StBelowRange;
          done_d  = 1'b1;
          state_d = SIdle;
        end else begin
          rd_addr = last_idx;
          state_d = SLast;
        end
      end
      SLast: begin
        last_cmd_d = rd_data_q.cmd;
        if (d_q > cur_meas) begin
          res_d   = cur_clamped;
          st_d    = StAboveRange;
          done_d  = 1'b1;
          state_d = SIdle;
        end else begin
          rd_addr = IdxW'(1);
          idx_d   = IdxW'(1);
          state_d = SScan;
        end
      end
      SScan: begin
        if ((d_q >= prev_meas) && (d_q <= cur_meas)) begin
          sy0_d   = prev_q.cmd;
          sy1_d   = rd_data_q.cmd;
          sx0_d   = prev_q.meas;
          dx_d    = rd_data_q.meas - prev_q.meas;
          state_d = SMul;
        end else if (idx_q == last_idx) begin
          // No segment holds the value: fall back to the last command.
          res_d   = last_clamped;
          st_d    = StAboveRange;
          done_d  = 1'b1;
          state_d = SIdle;
        end else begin
          prev_d  = rd_data_q;
          idx_d   = idx_q + IdxW'(1);
          rd_addr = idx_q + IdxW'(1);
        end
      end
      SMul: begin
        prod_d = dy * $signed({1'b0, dd[ValW-1:0]});
        if (dx_q == '0) begin
          q_d     = '0;
          state_d = SFin;
        end else begin
          state_d = SDiv;
        end
      end
      SDiv: begin
        if (div_done) begin
          // Floor division: a negative quotient with a remainder rounds one lower.
          if (prod_q[25]) begin
            q_d = -$signed({1'b0, q_mag}) - $signed({13'd0, div_rem_nz});
          end else begin
            q_d = $signed({1'b0, q_mag});
          end
          state_d = SFin;
        end
      end
      SFin: begin
        if (y > $signed({3'b000, FullScale})) begin
          res_d = FullScale;
          st_d  = StClampHigh;
        end else if (y < 0) begin
          res_d = '0;
          st_d  = StClampLow;
        end else begin
          res_d = y[ValW-1:0];
          st_d  = StCalibrated;
        end
        done_d  = 1'b1;
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (done_q && out_load) begin
      done_d = 1'b0;
    end
    if ((state_q == SMul) && (dx_q != '0)) begin
      div_start = 1'b1;
    end
  end

  // The product is registered in the multiply state, so the divider starts from prod_d.
  icm_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (prod_mag),
    .den_i    (dx_q),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  assign out_load = done_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    idx_q      <= idx_d;
    prev_q     <= prev_d;
    last_cmd_q <= last_cmd_d;
    sy0_q      <= sy0_d;
    sy1_q      <= sy1_d;
    sx0_q      <= sx0_d;
    dx_q       <= dx_d;
    prod_q     <= prod_d;
    q_q        <= q_d;
    res_q      <= res_d;
    st_q       <= st_d;
    if (out_load) begin
      out_cmd_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_incline_o = out_cmd_q;
  assign status_o          = out_st_q;

endmodule
